>>> src/fwrl_pkg.sv
// ----------------------------------------------------------------------------
// fwrl_pkg
// Shared types and constants of the per-source fixed-window rate limiter.
// ----------------------------------------------------------------------------
package fwrl_pkg;

   localparam int TABLE_SLOTS_DEFAULT = 1024;

   localparam int HASH_W        = 32;
   localparam int HASH_KEY_W    = 31;
   localparam int CHAR_W        = 8;
   localparam int TIME_W        = 32;
   localparam int COUNT_W       = 16;
   localparam int STRIKE_W      = 8;
   localparam int VERDICT_W     = 2;
   localparam int SLOT_INDEX_W  = 10;

   localparam int MOD_DIGIT_BITS = 4;
   localparam int MOD_STEPS      = HASH_W / MOD_DIGIT_BITS;
   localparam int MOD_CNT_W      = $clog2(MOD_STEPS);

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_SECONDS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REQUEST_LIMIT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRIKE_LIMIT   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAN_ENABLE     = 2'd3;

   localparam logic [COUNT_W-1:0]  WINDOW_SECONDS_RESET = 16'd60;
   localparam logic [COUNT_W-1:0]  REQUEST_LIMIT_RESET  = 16'd1000;
   localparam logic [STRIKE_W-1:0] STRIKE_LIMIT_RESET   = 8'd5;
   localparam logic [STRIKE_W-1:0] STRIKE_MAX           = 8'd255;

   localparam logic [VERDICT_W-1:0] VERDICT_ALLOWED = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_OVER    = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_BANNED  = 2'd2;

   typedef struct packed {
      logic [CHAR_W-1:0] ip_char;
      logic              last_char;
      logic [TIME_W-1:0] now_seconds;
   } req_item_type;

   typedef struct packed {
      logic [VERDICT_W-1:0]    verdict;
      logic [SLOT_INDEX_W-1:0] slot_index;
   } rsp_item_type;

   typedef struct packed {
      logic [TIME_W-1:0]   start;
      logic [COUNT_W-1:0]  count;
      logic [STRIKE_W-1:0] strikes;
      logic                banned;
   } slot_entry_type;

endpackage

>>> src/fwrl_slot_mod.sv
// ----------------------------------------------------------------------------
// fwrl_slot_mod
// Reduces a 31-bit hash key modulo the table size, four quotient bits per
// cycle; with a power-of-two table size the low key bits are taken directly.
// ----------------------------------------------------------------------------
module fwrl_slot_mod #(
   parameter int TABLE_SLOTS = fwrl_pkg::TABLE_SLOTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [fwrl_pkg::HASH_KEY_W-1:0]   dividend,
   output logic                              done,
   output logic [$clog2(TABLE_SLOTS)-1:0]    remainder
);

   localparam int AW = $clog2(TABLE_SLOTS);
   localparam bit SLOTS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
   localparam logic [AW:0] SLOTS_K = (AW + 1)'(TABLE_SLOTS);
   localparam logic [fwrl_pkg::MOD_CNT_W-1:0] LAST_STEP =
      fwrl_pkg::MOD_CNT_W'(fwrl_pkg::MOD_STEPS - 1);

   logic                                busy_ff;
   logic                                done_ff;
   logic [fwrl_pkg::MOD_CNT_W-1:0]      step_ff;
   logic [fwrl_pkg::HASH_W-1:0]         shift_ff;
   logic [AW-1:0]                       rem_ff;
   logic [AW-1:0]                       rem_in;

   always_comb begin
      logic [AW:0] r;
      rem_in = rem_ff;
      for (int i = 0; i < fwrl_pkg::MOD_DIGIT_BITS; i++) begin
         r = {rem_in, shift_ff[fwrl_pkg::HASH_W-1-i]};
         if (r >= SLOTS_K) begin
            r = r - SLOTS_K;
         end
         rem_in = r[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         if (start) begin
            if (SLOTS_POW2) begin
               rem_ff  <= dividend[AW-1:0];
               done_ff <= 1'b1;
            end else begin
               busy_ff  <= 1'b1;
               done_ff  <= 1'b0;
               step_ff  <= '0;
               shift_ff <= {1'b0, dividend};
               rem_ff   <= '0;
            end
         end else if (busy_ff) begin
            rem_ff   <= rem_in;
            shift_ff <= shift_ff << fwrl_pkg::MOD_DIGIT_BITS;
            step_ff  <= step_ff + 1'b1;
            busy_ff  <= (step_ff != LAST_STEP);
            done_ff  <= (step_ff == LAST_STEP);
         end else begin
            done_ff <= 1'b0;
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

>>> src/per_source_fixed_window_rate_limiter.sv
// ----------------------------------------------------------------------------
// per_source_fixed_window_rate_limiter
// Hashes a source address one character per item and applies a per-slot
// fixed-window request limit with strikes and an optional ban.
// ----------------------------------------------------------------------------
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   req_item_type
//   rsp_      out        rsp_valid/rsp_stall   rsp_item_type
//   csr_      in         csr_we                csr_index, csr_wdata
//
// A last character passes through the accepting cycle, the slot modulo
// unit, one table read and one write-back. After reset the table is swept
// to zero, one slot per cycle, with req_stall high. A held rsp item stalls
// only the write-back.
// ----------------------------------------------------------------------------
module per_source_fixed_window_rate_limiter #(
   parameter int TABLE_SLOTS = fwrl_pkg::TABLE_SLOTS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  fwrl_pkg::req_item_type             req_item,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output fwrl_pkg::rsp_item_type             rsp_item,
   input  logic                               csr_we,
   input  logic [fwrl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [fwrl_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int AW = $clog2(TABLE_SLOTS);
   localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SLOTS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_READ,
      ST_JUDGE
   } state_type;

   state_type                         state_ff;
   logic [AW-1:0]                     clr_addr_ff;
   logic [fwrl_pkg::HASH_W-1:0]       hash_ff;
   logic [fwrl_pkg::HASH_W-1:0]       hash_in;
   logic [fwrl_pkg::TIME_W-1:0]       now_ff;
   logic [AW-1:0]                     slot_ff;
   logic                              rsp_valid_ff;
   fwrl_pkg::rsp_item_type            rsp_item_ff;

   logic [fwrl_pkg::COUNT_W-1:0]      window_seconds_ff;
   logic [fwrl_pkg::COUNT_W-1:0]      request_limit_ff;
   logic [fwrl_pkg::STRIKE_W-1:0]     strike_limit_ff;
   logic                              ban_enable_ff;

   logic                              req_accept;
   logic                              rsp_free;
   logic                              mod_start;
   logic                              mod_done;
   logic [AW-1:0]                     mod_rem;

   fwrl_pkg::slot_entry_type          mem [TABLE_SLOTS];
   fwrl_pkg::slot_entry_type          rd_data_ff;
   logic                              mem_we;
   logic [AW-1:0]                     mem_waddr;
   fwrl_pkg::slot_entry_type          mem_wdata;

   fwrl_pkg::slot_entry_type          upd_entry;
   logic [fwrl_pkg::VERDICT_W-1:0]    upd_verdict;
   logic [fwrl_pkg::STRIKE_W-1:0]     strikes_inc;
   logic [fwrl_pkg::HASH_W-1:0]       slot_wide;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign mod_start  = req_accept && req_item.last_char;

   assign hash_in = (hash_ff << 7) + (hash_ff << 1) + hash_ff
                  + fwrl_pkg::HASH_W'(req_item.ip_char);

   fwrl_slot_mod #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_slot_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (hash_in[fwrl_pkg::HASH_KEY_W-1:0]),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_comb begin
      upd_entry   = rd_data_ff;
      upd_verdict = fwrl_pkg::VERDICT_ALLOWED;
      strikes_inc = (rd_data_ff.strikes < fwrl_pkg::STRIKE_MAX) ?
                    rd_data_ff.strikes + 1'b1 : rd_data_ff.strikes;
      if (rd_data_ff.banned) begin
         upd_verdict = fwrl_pkg::VERDICT_BANNED;
      end else if ((now_ff - rd_data_ff.start) >=
                   fwrl_pkg::TIME_W'(window_seconds_ff)) begin
         upd_entry.start = now_ff;
         upd_entry.count = fwrl_pkg::COUNT_W'(1);
      end else if (rd_data_ff.count >= request_limit_ff) begin
         upd_entry.start   = now_ff;
         upd_entry.count   = fwrl_pkg::COUNT_W'(1);
         upd_entry.strikes = strikes_inc;
         if (ban_enable_ff && (strikes_inc >= strike_limit_ff)) begin
            upd_entry.banned = 1'b1;
         end
         upd_verdict = fwrl_pkg::VERDICT_OVER;
      end else begin
         upd_entry.count = rd_data_ff.count + 1'b1;
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = slot_ff;
      mem_wdata = upd_entry;
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else if ((state_ff == ST_JUDGE) && rsp_free) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (state_ff == ST_READ) begin
         rd_data_ff <= mem[slot_ff];
      end
   end

   assign slot_wide = fwrl_pkg::HASH_W'(slot_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         hash_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == ST_JUDGE) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == LAST_SLOT) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_accept) begin
                  if (req_item.last_char) begin
                     hash_ff  <= '0;
                     now_ff   <= req_item.now_seconds;
                     state_ff <= ST_MOD;
                  end else begin
                     hash_ff <= hash_in;
                  end
               end
            end
            ST_MOD: begin
               if (mod_done) begin
                  slot_ff  <= mod_rem;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_JUDGE;
            end
            ST_JUDGE: begin
               if (rsp_free) begin
                  rsp_item_ff.verdict    <= upd_verdict;
                  rsp_item_ff.slot_index <= slot_wide[fwrl_pkg::SLOT_INDEX_W-1:0];
                  state_ff               <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_seconds_ff <= fwrl_pkg::WINDOW_SECONDS_RESET;
         request_limit_ff  <= fwrl_pkg::REQUEST_LIMIT_RESET;
         strike_limit_ff   <= fwrl_pkg::STRIKE_LIMIT_RESET;
         ban_enable_ff     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            fwrl_pkg::CSR_WINDOW_SECONDS: window_seconds_ff <= csr_wdata;
            fwrl_pkg::CSR_REQUEST_LIMIT:  request_limit_ff  <= csr_wdata;
            fwrl_pkg::CSR_STRIKE_LIMIT:
               strike_limit_ff <= csr_wdata[fwrl_pkg::STRIKE_W-1:0];
            fwrl_pkg::CSR_BAN_ENABLE:     ban_enable_ff     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the per-source fixed-window rate limiter. Address text is
// sent one character per item. A local model of the hash, the slot table and
// the limit registers predicts each verdict and slot. Every result is checked
// against the oldest prediction. Both channels idle at random, and one long
// receiver hold-off fills the block. Directed cases come first: field
// extremes, window expiry, over limit, strikes, bans, time running backwards,
// zero window, zero limits and strike saturation. Random address traffic
// under several limit settings follows.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import fwrl_pkg::*;

   localparam int SLOTS           = TABLE_SLOTS_DEFAULT;
   localparam int DRAIN_CYCLES    = 16;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int LIMIT_CYCLES    = 400000;
   localparam int POOL            = 10;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   logic [COUNT_W-1:0]  window_len;
   logic [COUNT_W-1:0]  request_cap;
   logic [STRIKE_W-1:0] strike_cap;
   logic                ban_on;
   logic [HASH_W-1:0]   hash_acc;
   slot_entry_type      slot_state [SLOTS];

   rsp_item_type verdicts_due [$];
   int unsigned  error_count      = 0;
   int unsigned  chars_sent       = 0;
   int unsigned  cycle_count      = 0;
   bit           sender_idles     = 1'b1;
   bit           receiver_idles   = 1'b1;
   bit           hold_off_request = 1'b0;

   per_source_fixed_window_rate_limiter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic bit rate_verdict(input req_item_type it, output rsp_item_type got);
      slot_entry_type    e;
      logic [HASH_W-1:0] slot;
      logic [TIME_W-1:0] elapsed;
      hash_acc = hash_acc * 32'd131 + 32'(it.ip_char);
      got = '0;
      if (!it.last_char)
         return 1'b0;
      slot = (hash_acc & 32'h7fff_ffff) % SLOTS;
      hash_acc = '0;
      e = slot_state[slot];
      elapsed = it.now_seconds - e.start;
      if (e.banned) begin
         got.verdict = VERDICT_BANNED;
      end else if (elapsed >= 32'(window_len)) begin
         e.start = it.now_seconds;
         e.count = 16'd1;
         got.verdict = VERDICT_ALLOWED;
      end else if (e.count >= request_cap) begin
         e.start = it.now_seconds;
         e.count = 16'd1;
         if (e.strikes != STRIKE_MAX)
            e.strikes = e.strikes + 8'd1;
         if (ban_on && e.strikes >= strike_cap)
            e.banned = 1'b1;
         got.verdict = VERDICT_OVER;
      end else begin
         e.count = e.count + 16'd1;
         got.verdict = VERDICT_ALLOWED;
      end
      slot_state[slot] = e;
      got.slot_index = slot[SLOT_INDEX_W-1:0];
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      if (error_count < 200)
         $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last,
                            input logic [TIME_W-1:0] stamp);
      req_item_type it;
      rsp_item_type want;
      it.ip_char     = ch;
      it.last_char   = last;
      it.now_seconds = stamp;
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall);
      chars_sent++;
      if (rate_verdict(it, want))
         verdicts_due.push_back(want);
   endtask

   task automatic send_address(input string text, input logic [TIME_W-1:0] stamp);
      for (int i = 0; i < text.len(); i++)
         send_char(text[i], i == text.len() - 1, (i == text.len() - 1) ? stamp : $urandom);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_limits(input logic [COUNT_W-1:0] ws, input logic [COUNT_W-1:0] rl,
                             input logic [STRIKE_W-1:0] sl, input logic be);
      logic [CSR_DATA_W-1:0] strike_word;
      logic [CSR_DATA_W-1:0] ban_word;
      strike_word = {8'($urandom), sl};
      ban_word    = {15'($urandom), be};
      csr_we    <= 1'b1;
      csr_index <= CSR_WINDOW_SECONDS;
      csr_wdata <= ws;
      @(posedge clock);
      csr_index <= CSR_REQUEST_LIMIT;
      csr_wdata <= rl;
      @(posedge clock);
      csr_index <= CSR_STRIKE_LIMIT;
      csr_wdata <= strike_word;
      @(posedge clock);
      csr_index <= CSR_BAN_ENABLE;
      csr_wdata <= ban_word;
      @(posedge clock);
      csr_we <= 1'b0;
      window_len  = ws;
      request_cap = rl;
      strike_cap  = sl;
      ban_on      = be;
   endtask

   function automatic string random_address();
      string       text;
      string       digits;
      int unsigned len;
      digits = "0123456789.";
      len    = $urandom_range(1, 6);
      text   = "......";
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 1) == 0)
            text.putc(i, digits[$urandom_range(0, 10)]);
         else
            text.putc(i, 8'($urandom_range(1, 255)));
      end
      return text.substr(0, len - 1);
   endfunction

   task automatic test_reset_settings();
      send_char(8'h00, 1'b1, 32'h0000_0000);
      send_char(8'hff, 1'b1, 32'hffff_ffff);
      send_address("ab", 32'd1000);
      send_address("ab", 32'd1010);
      drain_results();
   endtask

   task automatic test_window_and_limit();
      set_limits(16'd10, 16'd2, 8'd2, 1'b1);
      for (int i = 0; i < 7; i++)
         send_char("A", 1'b1, 32'd100 + 32'(i));
      send_char("B", 1'b1, 32'd50);
      send_char("B", 1'b1, 32'd40);
      send_char("B", 1'b1, 32'd45);
      drain_results();
   endtask

   task automatic test_open_cases();
      set_limits(16'd0, 16'hffff, 8'd0, 1'b1);
      send_char("C", 1'b1, 32'd5);
      send_char("C", 1'b1, 32'd5);
      drain_results();
      set_limits(16'hffff, 16'd0, 8'd0, 1'b1);
      send_char("D", 1'b1, 32'd7);
      send_char("D", 1'b1, 32'd8);
      drain_results();
      set_limits(16'hffff, 16'hffff, 8'hff, 1'b1);
      send_char("E", 1'b1, 32'd9);
      send_char("E", 1'b1, 32'd10);
      drain_results();
   endtask

   task automatic test_strike_saturation();
      set_limits(16'hffff, 16'd0, 8'hff, 1'b0);
      for (int i = 0; i < 258; i++)
         send_char("S", 1'b1, 32'd1 + 32'(i));
      drain_results();
      set_limits(16'hffff, 16'd0, 8'hff, 1'b1);
      send_char("S", 1'b1, 32'd300);
      send_char("S", 1'b1, 32'd301);
      drain_results();
   endtask

   task automatic test_backpressure();
      sender_idles     = 1'b0;
      hold_off_request = 1'b1;
      set_limits(16'd20, 16'd3, 8'd2, 1'b0);
      for (int i = 0; i < 20; i++) begin
         if (i % 2 != 0)
            send_address("7.7", 32'd5000 + 32'(i / 4));
         else
            send_address("9", 32'd5000 + 32'(i / 4));
      end
      drain_results();
      sender_idles = 1'b1;
   endtask

   task automatic test_random_traffic();
      string             pool [POOL];
      logic [TIME_W-1:0] clock_now;
      int unsigned       target;
      int unsigned       roll;
      int unsigned       n;
      string             text;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: set_limits(16'($urandom_range(5, 40)), 16'($urandom_range(1, 4)),
                          8'($urandom_range(1, 4)), 1'b0);
            1: set_limits(16'd1, 16'd1, 8'hff, 1'b1);
            2: set_limits(16'hffff, 16'($urandom_range(2, 6)), 8'($urandom_range(1, 3)), 1'b1);
            default: set_limits(16'($urandom_range(2, 20)), 16'($urandom_range(1, 3)),
                                8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)));
         endcase
         receiver_idles = (phase != 3);
         foreach (pool[k])
            pool[k] = random_address();
         clock_now = $urandom;
         target = chars_sent + 32;
         while (chars_sent < target) begin
            sender_idles = (phase != 3) && ($urandom_range(0, 3) != 0);
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
               n = $urandom_range(1, 4);
               for (int i = 0; i < n; i++)
                  send_char(8'($urandom), i == n - 1, $urandom);
            end else if (roll < 15) begin
               text = pool[$urandom_range(0, POOL - 1)];
               n = $urandom_range(1, text.len());
               for (int i = 0; i < n; i++)
                  send_char(text[i], 1'b0, $urandom);
               send_char(8'($urandom), 1'b1, clock_now);
            end else begin
               send_address(pool[$urandom_range(0, POOL - 1)], clock_now);
            end
            roll = $urandom_range(0, 99);
            if (roll < 3)
               clock_now = $urandom;
            else if (roll < 6)
               clock_now = clock_now - 32'($urandom_range(1, 100));
            else
               clock_now = clock_now + 32'($urandom_range(0, 2));
         end
         drain_results();
      end
   endtask

   initial begin : rsp_stall_driver
      int unsigned burst;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_request = 1'b0;
            rsp_stall <= 1'b0;
         end else if (receiver_idles && $urandom_range(0, 9) == 0) begin
            burst = $urandom_range(1, 19);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdicts_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result verdict %0d slot %0d",
                                      rsp_item.verdict, rsp_item.slot_index));
         end else begin
            want = verdicts_due.pop_front();
            if (rsp_item.verdict !== want.verdict)
               report_mismatch($sformatf("verdict got %0d want %0d (slot %0d)",
                                         rsp_item.verdict, want.verdict, want.slot_index));
            if (rsp_item.slot_index !== want.slot_index)
               report_mismatch($sformatf("slot_index got %0d want %0d",
                                         rsp_item.slot_index, want.slot_index));
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      window_len  = WINDOW_SECONDS_RESET;
      request_cap = REQUEST_LIMIT_RESET;
      strike_cap  = STRIKE_LIMIT_RESET;
      ban_on      = 1'b0;
      hash_acc    = '0;
      foreach (slot_state[i])
         slot_state[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_settings();
      test_window_and_limit();
      test_open_cases();
      test_strike_saturation();
      test_backpressure();
      test_random_traffic();
      drain_results();
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
